### rtl/rlf_pkg.sv
// Shared types, constants and pointer helpers for the run-length FIFO.
package rlf_pkg;

   // Ring geometry and field widths.
   localparam int DEPTH          = 16;
   localparam int COUNT_BITS     = 32;
   localparam int PTR_BITS       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int SYM_BITS       = 8;
   localparam int OUT_COUNT_BITS = 32;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
   localparam logic [PTR_BITS-1:0]   PTR_LAST  = PTR_BITS'(DEPTH - 1);

   // Operation codes.
   localparam logic [1:0] OP_ENQUEUE = 2'd0;
   localparam logic [1:0] OP_DEQUEUE = 2'd1;
   localparam logic [1:0] OP_DROP    = 2'd2;
   localparam logic [1:0] OP_CLEAR   = 2'd3;

   typedef struct packed {
      logic [1:0]          opcode;
      logic [SYM_BITS-1:0] symbol;
   } req_type;

   typedef struct packed {
      logic                      is_empty;
      logic                      is_full;
      logic                      dropped;
      logic [SYM_BITS-1:0]       head_symbol;
      logic [OUT_COUNT_BITS-1:0] head_count;
   } rsp_type;

   // One run as kept in the ring storage.
   typedef struct packed {
      logic [SYM_BITS-1:0]   symbol;
      logic [COUNT_BITS-1:0] count;
   } entry_type;

   // Ring pointer step forward, wrapping at DEPTH.
   function automatic logic [PTR_BITS-1:0] next_ptr(input logic [PTR_BITS-1:0] p);
      return (p == PTR_LAST) ? '0 : p + 1'b1;
   endfunction

   // Ring pointer step backward, wrapping at DEPTH.
   function automatic logic [PTR_BITS-1:0] prev_ptr(input logic [PTR_BITS-1:0] p);
      return (p == '0) ? PTR_LAST : p - 1'b1;
   endfunction

endpackage

### rtl/rlf_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module rlf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                        clock,
   input  logic                                        wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                            wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                            rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/run_length_fifo_unit.sv
// Run-length FIFO: a ring of symbol runs with merge, dequeue, drop-head and clear.
// Latency: the result beat for an item is valid in the cycle after the item is accepted.
// Throughput: one item per cycle while result beats are taken; the result register frees as its beat is taken.
// The oldest and newest runs live in registers; the run after the head is prefetched
// from the ring RAM every cycle, so a retire never waits on a memory read.
// Reset is synchronous: it empties the ring and drops any pending result, with no clearing pass.
module run_length_fifo_unit
   import rlf_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic [PTR_BITS-1:0]   head_ptr_ff, head_ptr_in;
   logic [PTR_BITS-1:0]   tail_ptr_ff, tail_ptr_in;
   logic [SYM_BITS-1:0]   head_sym_ff, head_sym_in;
   logic [COUNT_BITS-1:0] head_cnt_ff, head_cnt_in;
   logic [SYM_BITS-1:0]   last_sym_ff, last_sym_in;
   logic [COUNT_BITS-1:0] last_cnt_ff, last_cnt_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_data_ff, rsp_data_in;

   logic                  accept;
   logic                  is_empty;
   logic                  is_full;
   logic                  single_run;
   logic                  two_runs;
   logic                  retire;
   logic                  dropped;
   logic                  empty_next;
   logic [PTR_BITS-1:0]   last_ptr;
   logic [COUNT_BITS-1:0] merged_cnt;
   logic                  wr_en;
   logic [PTR_BITS-1:0]   wr_addr;
   entry_type             wr_entry;
   entry_type             next_entry;

   assign accept    = req_valid && req_ready;
   assign req_ready = !rsp_valid_ff || rsp_ready;

   // Ring occupancy as seen before this item.
   assign is_empty   = (head_ptr_ff == tail_ptr_ff);
   assign is_full    = (next_ptr(tail_ptr_ff) == head_ptr_ff);
   assign last_ptr   = prev_ptr(tail_ptr_ff);
   assign single_run = (next_ptr(head_ptr_ff) == tail_ptr_ff);
   assign two_runs   = (next_ptr(next_ptr(head_ptr_ff)) == tail_ptr_ff);
   assign merged_cnt = (last_cnt_ff == COUNT_MAX) ? last_cnt_ff : last_cnt_ff + 1'b1;

   // Item decode and state update.
   always_comb begin
      head_ptr_in = head_ptr_ff;
      tail_ptr_in = tail_ptr_ff;
      head_sym_in = head_sym_ff;
      head_cnt_in = head_cnt_ff;
      last_sym_in = last_sym_ff;
      last_cnt_in = last_cnt_ff;
      retire      = 1'b0;
      dropped     = 1'b0;
      wr_en       = 1'b0;
      wr_addr     = last_ptr;
      wr_entry    = '{symbol: req_data.symbol, count: merged_cnt};

      if (accept) begin
         unique case (req_data.opcode)
            OP_ENQUEUE: begin
               if (!is_empty && (last_sym_ff == req_data.symbol)) begin
                  // Merge into the newest run; the head copy follows when they coincide.
                  last_cnt_in = merged_cnt;
                  wr_en       = 1'b1;
                  if (single_run) begin
                     head_cnt_in = merged_cnt;
                  end
               end else if (is_full) begin
                  dropped = 1'b1;
               end else begin
                  // Append a new run at the tail.
                  wr_en       = 1'b1;
                  wr_addr     = tail_ptr_ff;
                  wr_entry    = '{symbol: req_data.symbol, count: COUNT_BITS'(1)};
                  last_sym_in = req_data.symbol;
                  last_cnt_in = COUNT_BITS'(1);
                  tail_ptr_in = next_ptr(tail_ptr_ff);
                  if (is_empty) begin
                     head_sym_in = req_data.symbol;
                     head_cnt_in = COUNT_BITS'(1);
                  end
               end
            end
            OP_DEQUEUE: begin
               if (!is_empty) begin
                  if (head_cnt_ff > COUNT_BITS'(1)) begin
                     head_cnt_in = head_cnt_ff - 1'b1;
                     if (single_run) begin
                        last_cnt_in = head_cnt_ff - 1'b1;
                     end
                  end else begin
                     retire = 1'b1;
                  end
               end
            end
            OP_DROP: begin
               retire = !is_empty;
            end
            OP_CLEAR: begin
               head_ptr_in = '0;
               tail_ptr_in = '0;
            end
         endcase
      end

      // Retiring the head brings in the next run: the newest run from its
      // registers, any other from the prefetched RAM entry.
      if (retire) begin
         head_ptr_in = next_ptr(head_ptr_ff);
         if (two_runs) begin
            head_sym_in = last_sym_ff;
            head_cnt_in = last_cnt_ff;
         end else begin
            head_sym_in = next_entry.symbol;
            head_cnt_in = next_entry.count;
         end
      end
   end

   // Result beat built from the state after the item.
   always_comb begin
      empty_next              = (head_ptr_in == tail_ptr_in);
      rsp_data_in.is_empty    = empty_next;
      rsp_data_in.is_full     = (next_ptr(tail_ptr_in) == head_ptr_in);
      rsp_data_in.dropped     = dropped;
      rsp_data_in.head_symbol = empty_next ? '0 : head_sym_in;
      rsp_data_in.head_count  = empty_next ? '0 : OUT_COUNT_BITS'(head_cnt_in);
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ptr_ff  <= '0;
         tail_ptr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ptr_ff  <= head_ptr_in;
         tail_ptr_ff  <= tail_ptr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Run and result payload registers.
   always_ff @(posedge clock) begin
      head_sym_ff <= head_sym_in;
      head_cnt_ff <= head_cnt_in;
      last_sym_ff <= last_sym_in;
      last_cnt_ff <= last_cnt_in;
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // Ring storage; the read port always fetches the run after the next head.
   rlf_ram #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_addr (next_ptr(head_ptr_in)),
      .rd_data (next_entry)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

### rtl/rlf_checker.sv
// Port-level checks for the run-length FIFO, bound to the top level.
module rlf_checker
   import rlf_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   // A stalled result beat holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result beat changed while stalled");

   // Every accepted item gives a result beat in the next cycle.
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("accepted item gave no result beat");

   // A clear always leaves the queue empty with a zero head.
   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_data.opcode == OP_CLEAR) |=>
         rsp_data.is_empty && !rsp_data.is_full && !rsp_data.dropped &&
         (rsp_data.head_count == '0))
      else $error("clear did not empty the queue");

   // A rejected enqueue only happens on a full ring.
   a_drop_when_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.dropped |-> rsp_data.is_full && !rsp_data.is_empty)
      else $error("dropped flagged on a ring that is not full");

   // A live head run always has a nonzero count; an empty queue shows zeros.
   a_head_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.is_empty == (rsp_data.head_count == '0)))
      else $error("head count disagrees with empty flag");

endmodule

bind run_length_fifo_unit rlf_checker u_rlf_checker (.*);

### verif/tb_run_length_fifo_unit.sv
// Self-checking testbench for the run-length FIFO: random traffic, status prediction, checks.
module tb_run_length_fifo_unit;
   import rlf_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // One queued operation; the sender may be told to wait until all status beats are back.
   typedef struct {
      req_type beat;
      bit      hold_until_drained;
   } queued_op_type;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   queued_op_type queued_ops[$];
   rsp_type       expected_status[$];

   // Run store as the block should hold it.
   logic [SYM_BITS-1:0]   run_sym_model [DEPTH];
   logic [COUNT_BITS-1:0] run_cnt_model [DEPTH];
   int unsigned           head_slot;
   int unsigned           tail_slot;

   int mismatches   = 0;
   int ops_sent     = 0;
   int status_seen  = 0;
   int total_ops    = 0;
   int send_gap     = 0;
   int accept_gap   = 0;
   int long_hold    = 0;

   run_length_fifo_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   function automatic int unsigned wrap_next(int unsigned p);
      return (p + 1 >= DEPTH) ? 0 : p + 1;
   endfunction

   // Retiring the oldest run zeroes its count and advances the head.
   function automatic void retire_oldest();
      run_cnt_model[head_slot] = '0;
      head_slot = wrap_next(head_slot);
   endfunction

   // Apply one operation to the run store and return the status the block must report.
   function automatic rsp_type apply_run_op(req_type beat);
      rsp_type     status;
      int unsigned newest;
      logic        rejected;
      newest   = (tail_slot == 0) ? DEPTH - 1 : tail_slot - 1;
      rejected = 1'b0;
      case (beat.opcode)
         OP_ENQUEUE: begin
            if (head_slot != tail_slot && run_sym_model[newest] == beat.symbol) begin
               // Merge into the newest live run; the count saturates.
               if (run_cnt_model[newest] != COUNT_MAX)
                  run_cnt_model[newest] = run_cnt_model[newest] + 1'b1;
            end else if (wrap_next(tail_slot) == head_slot) begin
               rejected = 1'b1;
            end else begin
               run_sym_model[tail_slot] = beat.symbol;
               run_cnt_model[tail_slot] = 1;
               tail_slot = wrap_next(tail_slot);
            end
         end
         OP_DEQUEUE: begin
            if (head_slot != tail_slot) begin
               if (run_cnt_model[head_slot] > 1)
                  run_cnt_model[head_slot] = run_cnt_model[head_slot] - 1'b1;
               else
                  retire_oldest();
            end
         end
         OP_DROP: begin
            if (head_slot != tail_slot)
               retire_oldest();
         end
         default: begin
            foreach (run_cnt_model[i]) run_cnt_model[i] = '0;
            head_slot = 0;
            tail_slot = 0;
         end
      endcase
      status.is_empty = (head_slot == tail_slot);
      status.is_full  = (wrap_next(tail_slot) == head_slot);
      status.dropped  = rejected;
      if (head_slot == tail_slot) begin
         status.head_symbol = '0;
         status.head_count  = '0;
      end else begin
         status.head_symbol = run_sym_model[head_slot];
         status.head_count  = OUT_COUNT_BITS'(run_cnt_model[head_slot]);
      end
      return status;
   endfunction

   task automatic add_op(logic [1:0] opcode, logic [7:0] symbol, bit hold);
      queued_op_type op;
      op.beat.opcode        = opcode;
      op.beat.symbol        = symbol;
      op.hold_until_drained = hold;
      queued_ops.push_back(op);
   endtask

   task automatic check_field(string what, logic [31:0] want, logic [31:0] seen);
      if (seen !== want) begin
         mismatches++;
         if (mismatches <= 10)
            $display("Mismatch on status beat %0d, %s: expected %h, got %h",
                     status_seen, what, want, seen);
      end
   endtask

   // Sender: predicts each accepted beat and offers the next one from the queue.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_data  <= '0;
         send_gap  = 0;
      end else begin
         if (req_valid && req_ready) begin
            expected_status.push_back(apply_run_op(req_data));
            ops_sent++;
         end
         if (!req_valid || req_ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (queued_ops.size() != 0 && (!queued_ops[0].hold_until_drained ||
                         (expected_status.size() == 0 && !rsp_valid))) begin
               if (queued_ops.size() > 150 && (ops_sent / 70) % 3 != 2 &&
                   $urandom_range(0, 5) == 0) begin
                  send_gap = $urandom_range(1, 13) - 1;
                  req_valid <= 1'b0;
               end else begin
                  req_data  <= queued_ops[0].beat;
                  req_valid <= 1'b1;
                  void'(queued_ops.pop_front());
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: checks each status beat against the oldest prediction and stalls at random.
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_ready  <= 1'b0;
         accept_gap = 0;
         long_hold  = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_status.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("Unexpected status beat: %p", rsp_data);
            end else begin
               want = expected_status.pop_front();
               check_field("is_empty", 32'(want.is_empty), 32'(rsp_data.is_empty));
               check_field("is_full", 32'(want.is_full), 32'(rsp_data.is_full));
               check_field("dropped", 32'(want.dropped), 32'(rsp_data.dropped));
               check_field("head_symbol", 32'(want.head_symbol), 32'(rsp_data.head_symbol));
               check_field("head_count", 32'(want.head_count), 32'(rsp_data.head_count));
            end
            status_seen++;
            // One long hold-off so the block backs up and stalls its input.
            if (status_seen == 400)
               long_hold = 90;
         end
         if (long_hold > 0) begin
            long_hold--;
            rsp_ready <= 1'b0;
         end else if (accept_gap > 0) begin
            accept_gap--;
            rsp_ready <= 1'b0;
         end else if (status_seen < total_ops - 150 && (status_seen / 90) % 3 != 1 &&
                      $urandom_range(0, 5) == 0) begin
            accept_gap = $urandom_range(1, 13) - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Stimulus, reset and end of run.
   initial begin
      logic [7:0] alphabet [3];
      logic [7:0] sym;
      int         mode;
      bit         drain_marked;
      drain_marked = 1'b0;
      foreach (run_sym_model[i]) run_sym_model[i] = '0;
      foreach (run_cnt_model[i]) run_cnt_model[i] = '0;
      head_slot = 0;
      tail_slot = 0;

      // Directed: empty-queue operations, merge, retire, full ring, clear.
      add_op(OP_DEQUEUE, 8'h5a, 1'b0);
      add_op(OP_DROP, 8'ha5, 1'b0);
      add_op(OP_ENQUEUE, 8'h00, 1'b0);
      add_op(OP_ENQUEUE, 8'h00, 1'b0);
      add_op(OP_ENQUEUE, 8'hff, 1'b0);
      add_op(OP_DEQUEUE, 8'hff, 1'b0);
      add_op(OP_DEQUEUE, 8'h00, 1'b0);
      add_op(OP_DROP, 8'h00, 1'b0);
      // The queue is empty again, so this symbol starts a new run.
      add_op(OP_ENQUEUE, 8'hff, 1'b0);
      for (int i = 1; i <= 14; i++)
         add_op(OP_ENQUEUE, 8'(i * 17), 1'b0);
      // The ring is full: a new run is rejected, a merge into the newest is not.
      add_op(OP_ENQUEUE, 8'haa, 1'b0);
      add_op(OP_ENQUEUE, 8'hee, 1'b0);
      add_op(OP_CLEAR, 8'h3c, 1'b0);
      add_op(OP_ENQUEUE, 8'hee, 1'b0);

      // Random segments of runs, fills, drains, noise and clears.
      add_op(OP_ENQUEUE, 8'($urandom_range(0, 255)), 1'b1);
      while (queued_ops.size() < 1780) begin
         if (!drain_marked && queued_ops.size() > 900) begin
            drain_marked = 1'b1;
            add_op(OP_DEQUEUE, 8'($urandom_range(0, 255)), 1'b1);
         end
         mode = $urandom_range(0, 9);
         if (mode <= 3) begin
            foreach (alphabet[i]) alphabet[i] = 8'($urandom_range(0, 255));
            repeat ($urandom_range(4, 12)) begin
               sym = alphabet[$urandom_range(0, 2)];
               repeat ($urandom_range(1, 8)) add_op(OP_ENQUEUE, sym, 1'b0);
               if ($urandom_range(0, 2) == 0)
                  add_op($urandom_range(0, 1) ? OP_DEQUEUE : OP_DROP,
                         8'($urandom_range(0, 255)), 1'b0);
            end
         end else if (mode <= 5) begin
            repeat ($urandom_range(20, 40))
               add_op(OP_ENQUEUE, 8'($urandom_range(0, 255)), 1'b0);
         end else if (mode <= 7) begin
            repeat ($urandom_range(10, 40))
               add_op(($urandom_range(0, 3) == 0) ? OP_DROP : OP_DEQUEUE,
                      8'($urandom_range(0, 255)), 1'b0);
         end else if (mode == 8) begin
            repeat ($urandom_range(10, 30))
               add_op(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)), 1'b0);
         end else begin
            add_op(OP_CLEAR, 8'($urandom_range(0, 255)), 1'b0);
         end
      end
      total_ops = queued_ops.size();

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      do @(posedge clock);
      while (queued_ops.size() != 0 || req_valid || expected_status.size() != 0);
      repeat (8) @(posedge clock);
      if (mismatches == 0 && expected_status.size() == 0)
         $display("PASS run_length_fifo_unit");
      else
         $display("FAIL run_length_fifo_unit");
      $finish;
   end

   // Watchdog far beyond the slowest legal run.
   initial begin
      #5_000_000;
      $display("FAIL run_length_fifo_unit");
      $finish;
   end

endmodule
